[rtl/core/stt_pkg.sv]
`default_nettype none

package stt_pkg;

  // Action codes carried on the input channel.
  localparam logic [2:0] ACT_SCAN   = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_MODIFY = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_CHECK  = 3'd4;

  // Result kinds.
  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // A scan reports at most this many expiries.
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  // Reset value of the one-shot type register.
  localparam logic [7:0] ONE_SHOT_RESET = 8'd1;

  // One timer slot as held in the slot memory.
  typedef struct packed {
    logic [31:0] start;
    logic [15:0] length;
    logic [7:0]  slot_type;
    logic [15:0] param;
  } slot_rec_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_SCAN,
    ST_END
  } state_t;

endpackage

`default_nettype wire

[rtl/core/software_timer_table_core.sv]
// Sequence: an item is captured in idle and then decoded; a check answer goes to the output
// register, add and modify write the slot in the write state, and remove clears its flag.
// Throughput: one item at a time; a scan visits one slot per cycle unless a full output
// register stalls it, via the single slot read port and one start-plus-length comparator.
// Reset (rst_n, synchronous, active low) clears the sequencer, the output valid flag,
// all active flags and sets the one-shot type to 1; slot contents are not cleared.
`default_nettype none

module software_timer_table_core #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [7:0]  in_timer_id,
  input  wire logic [7:0]  in_timer_type,
  input  wire logic [15:0] in_timer_length,
  input  wire logic [15:0] in_user_param,
  input  wire logic [31:0] in_now_tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [7:0]       out_fired_id,
  output logic [7:0]       out_fired_type,
  output logic [15:0]      out_fired_param,
  output logic             out_is_active,
  output logic             out_last_of_run
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [8:0] SLOT_LIM = 9'(SLOT_COUNT);
  localparam logic [stt_pkg::FIRE_CNT_W-1:0] LAST_FIRE =
    stt_pkg::FIRE_CNT_W'(stt_pkg::MAX_RESULTS - 1);

  // Control state.
  stt_pkg::state_t state_r, state_nxt;
  logic [7:0] one_shot_r;
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [stt_pkg::FIRE_CNT_W-1:0] fires_r, fires_nxt;
  logic pend_v_r, pend_v_nxt;
  logic out_valid_r, out_valid_nxt;

  // Captured item.
  logic [2:0]  act_r, act_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] param_r, param_nxt;
  logic [31:0] now_r, now_nxt;

  // Pending fire, held back until it is known whether it ends the run.
  logic [7:0]  pend_id_r, pend_id_nxt;
  logic [7:0]  pend_type_r, pend_type_nxt;
  logic [15:0] pend_param_r, pend_param_nxt;

  // Output register payload.
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_id_r, out_id_nxt;
  logic [7:0]  out_type_r, out_type_nxt;
  logic [15:0] out_param_r, out_param_nxt;
  logic        out_act_r, out_act_nxt;
  logic        out_last_r, out_last_nxt;

  // Slot memory.
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  stt_pkg::slot_rec_t ram_rd_data;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  stt_pkg::slot_rec_t ram_wr_data;

  // Shared compare unit and helpers.
  logic [31:0]      due_sum;
  logic             due;
  logic             in_range;
  logic [IDX_W-1:0] sel;
  logic             out_free;
  logic             scan_stall;
  logic             scan_done;

  stt_slot_ram #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  // Expiry test: wrapping start plus length against the current tick.
  assign due_sum = ram_rd_data.start + 32'(ram_rd_data.length);
  assign due     = active_r[idx_r] && (due_sum <= now_r);

  assign in_range = ({1'b0, id_r} < SLOT_LIM);
  assign sel      = id_r[IDX_W-1:0];
  assign out_free = !out_valid_r || out_ready;

  // Sequencer: next state, memory control and output loading.
  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    idx_nxt        = idx_r;
    fires_nxt      = fires_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    pend_type_nxt  = pend_type_r;
    pend_param_nxt = pend_param_r;
    act_nxt        = act_r;
    id_nxt         = id_r;
    type_nxt       = type_r;
    len_nxt        = len_r;
    param_nxt      = param_r;
    now_nxt        = now_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_type_nxt   = out_type_r;
    out_param_nxt  = out_param_r;
    out_act_nxt    = out_act_r;
    out_last_nxt   = out_last_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = idx_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r;
    ram_wr_data    = ram_rd_data;
    in_ready       = 1'b0;
    scan_stall     = 1'b0;
    scan_done      = 1'b0;

    case (state_r)
      stt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt   = in_action;
          id_nxt    = in_timer_id;
          type_nxt  = in_timer_type;
          len_nxt   = in_timer_length;
          param_nxt = in_user_param;
          now_nxt   = in_now_tick;
          state_nxt = stt_pkg::ST_DECODE;
        end
      end

      stt_pkg::ST_DECODE: begin
        state_nxt = stt_pkg::ST_IDLE;
        case (act_r)
          stt_pkg::ACT_SCAN: begin
            idx_nxt     = '0;
            fires_nxt   = '0;
            pend_v_nxt  = 1'b0;
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_nxt   = stt_pkg::ST_SCAN;
          end
          stt_pkg::ACT_ADD: begin
            if (in_range) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = sel;
              state_nxt   = stt_pkg::ST_WRITE;
            end
          end
          stt_pkg::ACT_MODIFY: begin
            if (in_range && active_r[sel]) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = sel;
              state_nxt   = stt_pkg::ST_WRITE;
            end
          end
          stt_pkg::ACT_REMOVE: begin
            if (in_range) begin
              active_nxt[sel] = 1'b0;
            end
          end
          stt_pkg::ACT_CHECK: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = stt_pkg::KIND_CHECK;
              out_id_nxt    = id_r;
              out_type_nxt  = '0;
              out_param_nxt = '0;
              out_act_nxt   = in_range && active_r[sel];
              out_last_nxt  = 1'b1;
            end else begin
              state_nxt = stt_pkg::ST_DECODE;
            end
          end
          default: begin
            state_nxt = stt_pkg::ST_IDLE;
          end
        endcase
      end

      // Add or modify: an add on an active slot keeps the stored type.
      stt_pkg::ST_WRITE: begin
        ram_wr_en             = 1'b1;
        ram_wr_addr           = sel;
        ram_wr_data.start     = now_r;
        ram_wr_data.length    = len_r;
        ram_wr_data.slot_type = active_r[sel] ? ram_rd_data.slot_type : type_r;
        ram_wr_data.param     = param_r;
        active_nxt[sel]       = 1'b1;
        state_nxt             = stt_pkg::ST_IDLE;
      end

      // One slot per cycle unless stalled; the next slot is read as this one is updated.
      stt_pkg::ST_SCAN: begin
        scan_stall = due && pend_v_r && !out_free;
        if (!scan_stall) begin
          if (due) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = stt_pkg::KIND_FIRE;
              out_id_nxt    = pend_id_r;
              out_type_nxt  = pend_type_r;
              out_param_nxt = pend_param_r;
              out_act_nxt   = 1'b0;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_id_nxt    = 8'(idx_r);
            pend_type_nxt  = ram_rd_data.slot_type;
            pend_param_nxt = ram_rd_data.param;
            fires_nxt      = fires_r + 1'b1;
            if (ram_rd_data.slot_type == one_shot_r) begin
              active_nxt[idx_r] = 1'b0;
            end else begin
              ram_wr_en         = 1'b1;
              ram_wr_data.start = now_r;
            end
          end
          scan_done = (idx_r == LAST_IDX) || (due && (fires_r == LAST_FIRE));
          if (scan_done) begin
            state_nxt = stt_pkg::ST_END;
          end else begin
            idx_nxt     = idx_r + 1'b1;
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r + 1'b1;
          end
        end
      end

      // Release the held fire as the last result of the run.
      stt_pkg::ST_END: begin
        if (!pend_v_r) begin
          state_nxt = stt_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = stt_pkg::KIND_FIRE;
          out_id_nxt    = pend_id_r;
          out_type_nxt  = pend_type_r;
          out_param_nxt = pend_param_r;
          out_act_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = stt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = stt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stt_pkg::ST_IDLE;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      one_shot_r  <= stt_pkg::ONE_SHOT_RESET;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        one_shot_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    fires_r      <= fires_nxt;
    act_r        <= act_nxt;
    id_r         <= id_nxt;
    type_r       <= type_nxt;
    len_r        <= len_nxt;
    param_r      <= param_nxt;
    now_r        <= now_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_type_r  <= pend_type_nxt;
    pend_param_r <= pend_param_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_type_r   <= out_type_nxt;
    out_param_r  <= out_param_nxt;
    out_act_r    <= out_act_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_fired_id    = out_id_r;
  assign out_fired_type  = out_type_r;
  assign out_fired_param = out_param_r;
  assign out_is_active   = out_act_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

[rtl/core/stt_slot_ram.sv]
`default_nettype none

module stt_slot_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output stt_pkg::slot_rec_t      rd_data,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire stt_pkg::slot_rec_t wr_data
);

  stt_pkg::slot_rec_t mem [DEPTH];
  stt_pkg::slot_rec_t rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/stt_checker.sv]
`default_nettype none

module stt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_result_kind,
  input wire logic [7:0]  out_fired_id,
  input wire logic [7:0]  out_fired_type,
  input wire logic [15:0] out_fired_param,
  input wire logic        out_is_active,
  input wire logic        out_last_of_run
);

  // A stalled result stays valid and holds its id, param and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_id) &&
      $stable(out_fired_param) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // A check answer is always a single, final result with empty timer fields.
  a_check_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == stt_pkg::KIND_CHECK) |->
      out_last_of_run && (out_fired_type == 8'd0) && (out_fired_param == 16'd0))
    else $error("malformed check answer");

  // A fire result never reports the active flag.
  a_fire_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == stt_pkg::KIND_FIRE) |-> !out_is_active)
    else $error("fire result with active flag set");

  // The sequencer is busy in the cycle after each input transfer.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // No result is offered straight after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind software_timer_table_core stt_checker u_stt_checker (.*);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int NSLOT = 16;
  // Settling pause, sized from the slot count so that a scan of every slot can finish.
  localparam int SETTLE_CYCLES = NSLOT + 8;
  localparam logic [2:0] ACT_SPARE_LO = stt_pkg::ACT_CHECK + 3'd1;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  timer_id;
    logic [7:0]  timer_type;
    logic [15:0] timer_length;
    logic [15:0] user_param;
    logic [31:0] now_tick;
  } timer_cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  fired_id;
    logic [7:0]  fired_type;
    logic [15:0] fired_param;
    logic        is_active;
    logic        last_of_run;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = stt_pkg::ACT_SCAN;
  logic [7:0]  in_timer_id = '0;
  logic [7:0]  in_timer_type = '0;
  logic [15:0] in_timer_length = '0;
  logic [15:0] in_user_param = '0;
  logic [31:0] in_now_tick = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_fired_id;
  logic [7:0]  out_fired_type;
  logic [15:0] out_fired_param;
  logic        out_is_active;
  logic        out_last_of_run;

  software_timer_table_core #(
    .SLOT_COUNT(NSLOT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_timer_id(in_timer_id),
    .in_timer_type(in_timer_type),
    .in_timer_length(in_timer_length),
    .in_user_param(in_user_param),
    .in_now_tick(in_now_tick),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_kind(out_result_kind),
    .out_fired_id(out_fired_id),
    .out_fired_type(out_fired_type),
    .out_fired_param(out_fired_param),
    .out_is_active(out_is_active),
    .out_last_of_run(out_last_of_run)
  );

  // Shadow copy of the timer table and the one-shot register.
  logic [NSLOT-1:0] slot_on = '0;
  logic [31:0]      slot_t0   [NSLOT];
  logic [15:0]      slot_len  [NSLOT];
  logic [7:0]       slot_kind [NSLOT];
  logic [15:0]      slot_arg  [NSLOT];
  logic [7:0]       one_shot_code = stt_pkg::ONE_SHOT_RESET;

  timer_cmd_t   pending_cmds [$];
  timer_event_t expected_events [$];
  timer_cmd_t   drive_cmd;
  timer_event_t want_event;

  logic        in_xfer = 1'b0;
  int          in_gap = 0;
  int          out_hold = 0;
  int          calm_in = 0;
  int          calm_out = 0;
  int          err_count = 0;
  int          cmds_sent = 0;
  int          fires_seen = 0;
  int          checks_seen = 0;
  int          settings_used = 1;
  logic [31:0] tick = 32'h0001_0000;

  // Clock generation.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Prints one line for a mismatch, up to MAX_PRINTED of them, and counts it.
  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Idle length: mostly none, some short, a few long, with calm stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one accepted command to the shadow table and queues the results it causes.
  function automatic void apply_timer_cmd(input timer_cmd_t c);
    timer_event_t ev;
    logic         in_range;
    logic [31:0]  due;
    int           n;
    n = 0;
    in_range = (c.timer_id < NSLOT);
    case (c.action)
      stt_pkg::ACT_SCAN: begin
        for (int i = 0; i < NSLOT; i++) begin
          due = slot_t0[i] + {16'd0, slot_len[i]};
          if (slot_on[i] && due <= c.now_tick && n < stt_pkg::MAX_RESULTS) begin
            ev = '0;
            ev.result_kind = stt_pkg::KIND_FIRE;
            ev.fired_id = 8'(i);
            ev.fired_type = slot_kind[i];
            ev.fired_param = slot_arg[i];
            expected_events.push_back(ev);
            n++;
            if (slot_kind[i] == one_shot_code) begin
              slot_on[i] = 1'b0;
            end else begin
              slot_t0[i] = c.now_tick;
            end
          end
        end
      end
      stt_pkg::ACT_ADD: begin
        if (in_range) begin
          if (!slot_on[c.timer_id]) begin
            slot_on[c.timer_id] = 1'b1;
            slot_kind[c.timer_id] = c.timer_type;
          end
          slot_len[c.timer_id] = c.timer_length;
          slot_arg[c.timer_id] = c.user_param;
          slot_t0[c.timer_id] = c.now_tick;
        end
      end
      stt_pkg::ACT_MODIFY: begin
        if (in_range && slot_on[c.timer_id]) begin
          slot_len[c.timer_id] = c.timer_length;
          slot_arg[c.timer_id] = c.user_param;
          slot_t0[c.timer_id] = c.now_tick;
        end
      end
      stt_pkg::ACT_REMOVE: begin
        if (in_range) slot_on[c.timer_id] = 1'b0;
      end
      stt_pkg::ACT_CHECK: begin
        ev = '0;
        ev.result_kind = stt_pkg::KIND_CHECK;
        ev.fired_id = c.timer_id;
        ev.is_active = in_range ? slot_on[c.timer_id] : 1'b0;
        expected_events.push_back(ev);
        n = 1;
      end
      default: begin
      end
    endcase
    // Mark the final result of this command.
    if (n > 0) begin
      ev = expected_events.pop_back();
      ev.last_of_run = 1'b1;
      expected_events.push_back(ev);
    end
  endfunction

  // Input transfers feed the predictor; output transfers are checked in order.
  always @(posedge clk) begin
    if (rst_n) begin
      in_xfer <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        apply_timer_cmd({in_action, in_timer_id, in_timer_type, in_timer_length,
                         in_user_param, in_now_tick});
        cmds_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          flag_error($sformatf("unexpected result, kind %0d id %0d",
                               out_result_kind, out_fired_id));
        end else begin
          want_event = expected_events.pop_front();
          if (want_event.result_kind == stt_pkg::KIND_FIRE) fires_seen++;
          else checks_seen++;
          compare_field("result_kind", 16'(out_result_kind), 16'(want_event.result_kind));
          compare_field("fired_id", 16'(out_fired_id), 16'(want_event.fired_id));
          compare_field("fired_type", 16'(out_fired_type), 16'(want_event.fired_type));
          compare_field("fired_param", out_fired_param, want_event.fired_param);
          compare_field("is_active", 16'(out_is_active), 16'(want_event.is_active));
          compare_field("last_of_run", 16'(out_last_of_run), 16'(want_event.last_of_run));
        end
      end
    end else begin
      in_xfer <= 1'b0;
    end
  end

  // Driver for the command channel and the result back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_xfer) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          drive_cmd = pending_cmds.pop_front();
          in_action <= drive_cmd.action;
          in_timer_id <= drive_cmd.timer_id;
          in_timer_type <= drive_cmd.timer_type;
          in_timer_length <= drive_cmd.timer_length;
          in_user_param <= drive_cmd.user_param;
          in_now_tick <= drive_cmd.now_tick;
          in_valid <= 1'b1;
          in_gap = pick_gap(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_hold = pick_gap(calm_out);
        out_ready <= (out_hold == 0);
        if (out_hold > 0) out_hold = out_hold - 1;
      end
    end
  end

  task automatic send(input logic [2:0] action, input logic [7:0] id,
                      input logic [7:0] typ, input logic [15:0] len,
                      input logic [15:0] param, input logic [31:0] now);
    pending_cmds.push_back({action, id, typ, len, param, now});
  endtask

  // Waits until every command has gone and every result has arrived, then settles.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_one_shot(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    one_shot_code = value;
  endtask

  // Random traffic: mostly in-range table operations with time that mostly advances.
  task automatic gen_random(input int target);
    int          counted;
    int          r;
    logic [7:0]  id;
    logic [7:0]  typ;
    logic [15:0] len;
    logic [15:0] prm;
    counted = 0;
    while (counted < target) begin
      tick = tick + $urandom_range(0, 12);
      if ($urandom_range(0, 49) == 0) tick = $urandom();
      id = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(NSLOT, 255))
                                         : 8'($urandom_range(0, NSLOT - 1));
      typ = $urandom_range(0, 1) ? one_shot_code : 8'($urandom_range(0, 255));
      prm = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 70) len = 16'($urandom_range(0, 30));
      else if (r < 90) len = 16'($urandom_range(0, 300));
      else len = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send(stt_pkg::ACT_ADD, id, typ, len, prm, tick);
      end else if (r < 55) begin
        send(stt_pkg::ACT_SCAN, id, typ, len, prm, tick);
      end else if (r < 70) begin
        send(stt_pkg::ACT_CHECK, id, typ, len, prm, tick);
      end else if (r < 82) begin
        send(stt_pkg::ACT_MODIFY, id, typ, len, prm, tick);
      end else if (r < 92) begin
        send(stt_pkg::ACT_REMOVE, id, typ, len, prm, tick);
      end else if (r < 95) begin
        // Unused action codes are ignored and do not count.
        send(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), id, typ, len, prm, tick);
        counted--;
      end else begin
        // Arm every slot with a short period, then scan once all are due.
        for (int i = 0; i < NSLOT; i++) begin
          typ = $urandom_range(0, 1) ? one_shot_code : 8'($urandom_range(0, 255));
          send(stt_pkg::ACT_ADD, 8'(i), typ, 16'($urandom_range(0, 3)),
               16'($urandom_range(0, 65535)), tick);
        end
        tick = tick + 4;
        send(stt_pkg::ACT_SCAN, 8'd0, 8'd0, 16'd0, 16'd0, tick);
        counted = counted + NSLOT;
      end
      if (r < 92 && id >= NSLOT && r >= 55) counted--;
      counted++;
    end
  endtask

  // Main sequence: reset, directed cases, then random phases under several settings.
  initial begin
    logic [7:0] settings [4];
    logic [31:0] t;
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = 8'($urandom_range(2, 254));
    settings[3] = stt_pkg::ONE_SHOT_RESET;
    t = 32'h0001_0000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset value of the one-shot register.
    send(stt_pkg::ACT_SCAN, 8'd0, 8'd0, 16'd0, 16'd0, 32'd0);
    send(stt_pkg::ACT_CHECK, 8'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(stt_pkg::ACT_CHECK, 8'hFF, 8'd0, 16'd0, 16'd0, 32'd0);
    send(stt_pkg::ACT_ADD, 8'd0, stt_pkg::ONE_SHOT_RESET, 16'd0, 16'hFFFF, t);
    send(stt_pkg::ACT_ADD, 8'(NSLOT - 1), 8'hFF, 16'hFFFF, 16'd0, t);
    send(stt_pkg::ACT_ADD, 8'(NSLOT), 8'h55, 16'd1, 16'd1, t);
    send(stt_pkg::ACT_ADD, 8'hFF, 8'hAA, 16'd2, 16'd2, t);
    send(stt_pkg::ACT_CHECK, 8'd0, 8'd0, 16'd0, 16'd0, t);
    send(stt_pkg::ACT_CHECK, 8'(NSLOT), 8'd0, 16'd0, 16'd0, t);
    // An add on an active slot reloads it but keeps its type.
    send(stt_pkg::ACT_ADD, 8'd0, 8'h07, 16'd5, 16'h1234, t);
    send(stt_pkg::ACT_MODIFY, 8'd3, 8'd0, 16'd9, 16'd9, t);
    // Start near the top of the tick range so that start plus length wraps.
    send(stt_pkg::ACT_ADD, 8'd3, 8'h02, 16'd3, 16'hA5A5, 32'hFFFF_FFFE);
    send(stt_pkg::ACT_MODIFY, 8'd3, 8'd0, 16'd10, 16'h5A5A, 32'hFFFF_FFFF);
    send(stt_pkg::ACT_MODIFY, 8'(NSLOT + 1), 8'd0, 16'd1, 16'd1, t);
    send(stt_pkg::ACT_SCAN, 8'd0, 8'd0, 16'd0, 16'd0, t + 4);
    send(stt_pkg::ACT_SCAN, 8'd0, 8'd0, 16'd0, 16'd0, t + 5);
    send(stt_pkg::ACT_CHECK, 8'd0, 8'd0, 16'd0, 16'd0, t);
    send(stt_pkg::ACT_SCAN, 8'd0, 8'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send(stt_pkg::ACT_REMOVE, 8'(NSLOT - 1), 8'd0, 16'd0, 16'd0, t);
    send(stt_pkg::ACT_REMOVE, 8'd200, 8'd0, 16'd0, 16'd0, t);
    send(ACT_SPARE_LO, 8'd3, 8'hFF, 16'hFFFF, 16'hFFFF, t);
    send(ACT_SPARE_LO + 3'd1, 8'd3, 8'd0, 16'd0, 16'd0, t);
    send(ACT_SPARE_HI, 8'd3, 8'hFF, 16'hFFFF, 16'hFFFF, t);
    send(stt_pkg::ACT_CHECK, 8'(NSLOT - 1), 8'd0, 16'd0, 16'd0, t);
    send(stt_pkg::ACT_CHECK, 8'd3, 8'd0, 16'd0, 16'd0, t);

    // Random phases, each under its own one-shot type.
    foreach (settings[k]) begin
      wait_idle();
      write_one_shot(settings[k]);
      settings_used++;
      gen_random(110);
    end
    wait_idle();

    $display("Run covered %0d commands over %0d one-shot type settings,", cmds_sent,
             settings_used);
    $display("with %0d timer expiries and %0d status answers compared.", fires_seen,
             checks_seen);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a run that stalls.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still outstanding.", expected_events.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
